// ===== sv/hfc_pkg.sv =====
// Package with the constants and conversion functions of the half float converter.
package hfc_pkg;

	localparam int unsigned OperandWidth = 32;
	localparam int unsigned ResultWidth  = 32;

	localparam logic CMD_S2H = 1'b0;
	localparam logic CMD_H2S = 1'b1;

	localparam logic [15:0] INF16  = 16'h7c00;
	localparam logic [31:0] INF32  = 32'h7f800000;

	function automatic logic [15:0] single_to_half(input logic [31:0] x);
		logic        sgn;
		logic [7:0]  ex8;
		logic [23:0] man;
		logic [23:0] shf;
		logic [4:0]  amt;
		logic [14:0] sub;
		logic [9:0]  top;
		logic [24:0] rnd;
		logic [15:0] r;
		sgn = x[31];
		ex8 = x[30:23];
		man = {1'b1, x[22:0]};
		r = {sgn, 15'd0};
		if (ex8 <= 8'd112) begin
			if (ex8 >= 8'd102) begin
				amt = 5'(8'd113 - ex8);
				shf = man >> amt;
				sub = {4'd0, shf[23:13]};
				if (shf[12]) begin
					sub = sub + 15'd1;
				end
				r = {sgn, sub};
			end
		end else if (ex8 == 8'hff) begin
			top = x[22:13];
			if (x[22:0] == 23'd0) begin
				r = {sgn, INF16[14:0]};
			end else begin
				r = {sgn, INF16[14:10], top[9:1], top[0] | (top == 10'd0)};
			end
		end else begin
			rnd = {2'b00, ex8 - 8'd112, 15'd0} + {2'b00, 8'd0, x[22:13], 5'd0}
				+ {19'd0, x[12], 5'd0};
			if (rnd[24:20] != 5'd0 || rnd[19:15] == 5'd31) begin
				r = {sgn, INF16[14:0]};
			end else begin
				r = {sgn, rnd[19:5]};
			end
		end
		return r;
	endfunction

	function automatic logic [31:0] half_to_single(input logic [15:0] h);
		logic       sgn;
		logic [4:0] ex;
		logic [9:0] man;
		logic [3:0] lz;
		logic [9:0] nm;
		logic [7:0] e8;
		logic [31:0] r;
		sgn = h[15];
		ex = h[14:10];
		man = h[9:0];
		lz = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (man[i]) begin
				lz = 4'(9 - i);
			end
		end
		if (ex == 5'd0) begin
			if (man == 10'd0) begin
				r = {sgn, 31'd0};
			end else begin
				nm = man << (lz + 4'd1);
				e8 = 8'(8'd113 - 8'(lz) - 8'd1);
				r = {sgn, e8, nm, 13'd0};
			end
		end else if (ex == 5'd31) begin
			r = {sgn, INF32[30:23], man, 13'd0};
		end else begin
			r = {sgn, 8'(ex) + 8'd112, man, 13'd0};
		end
		return r;
	endfunction

endpackage

// ===== sv/half_float_converter_core.sv =====
// Top level of the half float converter, one registered pass per beat.
//  channel  dir  fields
//  s_axis   in   tuser = cmd, tdata = operand_bits
//  m_axis   out  tdata = result_bits
// One beat per cycle while m_axis takes results; each result is registered.
// The result register refills whenever it is empty or being taken.
// arst_n clears the valid flag only.
// A stall on m_axis holds s_axis_tready low until the result is taken.
module half_float_converter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // operand_bits[31:0]
	input  logic        s_axis_tuser,  // cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // result_bits[31:0]
);

	logic        valid_q;
	logic [31:0] res_q;
	logic [31:0] res_d;

	assign s_axis_tready = !valid_q || m_axis_tready;
	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = res_q;

	always_comb begin
		if (s_axis_tuser == hfc_pkg::CMD_H2S) begin
			res_d = hfc_pkg::half_to_single(s_axis_tdata[15:0]);
		end else begin
			res_d = {16'd0, hfc_pkg::single_to_half(s_axis_tdata)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			res_q <= res_d;
		end
	end

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("accepted beat did not produce a result");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");
	a_half: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == hfc_pkg::CMD_S2H
		|=> m_axis_tdata[31:16] == 16'd0)
		else $error("half result not zero extended");

endmodule
